// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SLE_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define SLE_NEVER(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define SLE_ASSERT(label, clk, rstn, prop, msg)
`define SLE_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

// ===== rtl/core/sle_pkg.sv =====
// Types and constants of the list engine.
package sle_pkg;

  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefDataWidth = 32;
  localparam int unsigned ValueWidth   = 32;

  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_POP_BACK   = 3'd1,
    MODE_PUSH_FRONT = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_INSERT     = 3'd4,
    MODE_ERASE      = 3'd5,
    MODE_FIND       = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ERASE  = 2'd2
  } cell_op_e;

  typedef struct packed {
    status_e status;
    logic    found;
  } req_res_t;

endpackage

// ===== rtl/core/sle_cell.sv =====
// One storage cell of the list chain: holds an element, shifts and compares.
module sle_cell #(
  parameter int unsigned DATA_WIDTH = sle_pkg::DefDataWidth,
  parameter int unsigned IW         = 4,
  parameter int unsigned CW         = 5
) (
  input  logic                  clk_i,
  input  sle_pkg::cell_op_e     op_i,
  input  logic [IW-1:0]         at_i,
  input  logic [IW-1:0]         idx_i,
  input  logic [CW-1:0]         count_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  hit_o
);
  import sle_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (op_i)
      CELL_INSERT: begin
        if (idx_i == at_i) begin
          data_d = value_i;
        end else if (idx_i > at_i) begin
          data_d = left_i;
        end
      end
      CELL_ERASE: begin
        if (idx_i >= at_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = (CW'(idx_i) < count_i) && (data_q == value_i);

endmodule

// ===== rtl/core/sle_ctrl.sv =====
// Request decoder of the list engine: checks, cell command and new count.
module sle_ctrl #(
  parameter int unsigned DEPTH = sle_pkg::DefDepth,
  parameter int unsigned IW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic              req_i,
  input  logic [2:0]        mode_i,
  input  logic [CW-1:0]     position_i,
  input  logic [CW-1:0]     count_i,
  input  logic              any_hit_i,
  output sle_pkg::cell_op_e op_o,
  output logic [IW-1:0]     at_o,
  output logic [CW-1:0]     count_o,
  output sle_pkg::req_res_t res_o
);
  import sle_pkg::*;

  localparam int unsigned CMPW = CW + 1;

  logic            full, empty;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  cell_op_e        op;

  assign full    = (count_i == CW'(DEPTH));
  assign empty   = (count_i == '0);
  assign pos_ext = CMPW'(position_i);
  assign cnt_ext = CMPW'(count_i);

  always_comb begin
    op           = CELL_HOLD;
    at_o         = '0;
    count_o      = count_i;
    res_o.status = ST_OK;
    res_o.found  = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_PUSH_BACK: begin
        if (full) begin
          res_o.status = ST_FULL;
        end else begin
          op      = CELL_INSERT;
          at_o    = IW'(count_i);
          count_o = count_i + CW'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          res_o.status = ST_EMPTY;
        end else begin
          count_o = count_i - CW'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          res_o.status = ST_FULL;
        end else begin
          op      = CELL_INSERT;
          count_o = count_i + CW'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          res_o.status = ST_EMPTY;
        end else begin
          op      = CELL_ERASE;
          count_o = count_i - CW'(1);
        end
      end
      MODE_INSERT: begin
        if (full) begin
          res_o.status = ST_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
          res_o.status = ST_BADPOS;
        end else begin
          op      = CELL_INSERT;
          at_o    = IW'(position_i - CW'(1));
          count_o = count_i + CW'(1);
        end
      end
      MODE_ERASE: begin
        if (empty) begin
          res_o.status = ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          res_o.status = ST_BADPOS;
        end else begin
          op      = CELL_ERASE;
          at_o    = IW'(position_i - CW'(1));
          count_o = count_i - CW'(1);
        end
      end
      MODE_FIND: begin
        if (empty) begin
          res_o.status = ST_EMPTY;
        end else if (any_hit_i) begin
          res_o.found = 1'b1;
        end else begin
          res_o.status = ST_NOTFOUND;
        end
      end
      default: begin
        op = CELL_HOLD;
      end
    endcase
  end

  assign op_o = req_i ? op : CELL_HOLD;

endmodule

// ===== rtl/core/sequential_list_engine.sv =====
// Top level of the list engine: a chain of element cells and a request decoder.
//
// A request is taken on a rising edge with start_i high and busy_o low. The
// block never stalls, so busy_o stays low and one request may be given in
// every cycle. mode_i selects push back, pop back, push front, pop front,
// insert, erase or find; value_i is the element or search key and position_i
// the 1-based place for insert and erase.
// Each request gives one result in the cycle after it is taken: done_o is high
// for that one cycle with status_o, found_value_o and count_o beside it.
// The receiver cannot hold a result off, so none is ever kept back.
// Throughput is one item per cycle: every cell shifts towards its neighbour
// and compares its element in the same cycle, so the length of the list does
// not change the timing.
// Reset empties the list at once; no clearing pass is needed, since cells
// beyond the count are never read.
`include "assert_macros.svh"

module sequential_list_engine #(
  parameter int unsigned DEPTH      = sle_pkg::DefDepth,
  parameter int unsigned DATA_WIDTH = sle_pkg::DefDataWidth,
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [2:0]                     mode_i,
  input  logic signed [sle_pkg::ValueWidth-1:0] value_i,
  input  logic [CW-1:0]                  position_i,
  output logic                           done_o,
  output logic [2:0]                     status_o,
  output logic signed [sle_pkg::ValueWidth-1:0] found_value_o,
  output logic [CW-1:0]                  count_o
);
  import sle_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                          accept;
  logic signed [DATA_WIDTH-1:0]  value_w;
  logic [DATA_WIDTH-1:0]         cell_data [DEPTH];
  logic [DEPTH-1:0]              hits;
  cell_op_e                      cell_op;
  logic [IW-1:0]                 cell_at;
  logic [CW-1:0]                 count_q, count_d;
  req_res_t                      res;
  logic                          done_q;
  status_e                       status_q;
  logic [ValueWidth-1:0]         found_q, found_d;

  assign busy_o  = 1'b0;
  assign accept  = start_i & ~busy_o;
  assign value_w = DATA_WIDTH'(value_i);

  sle_ctrl #(
    .DEPTH(DEPTH),
    .IW   (IW),
    .CW   (CW)
  ) u_ctrl (
    .req_i     (accept),
    .mode_i    (mode_i),
    .position_i(position_i),
    .count_i   (count_q),
    .any_hit_i (|hits),
    .op_o      (cell_op),
    .at_o      (cell_at),
    .count_o   (count_d),
    .res_o     (res)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = cell_data[g];
    end else begin : g_mid
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_inner
      assign right = cell_data[g+1];
    end

    sle_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IW        (IW),
      .CW        (CW)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op),
      .at_i   (cell_at),
      .idx_i  (IW'(g)),
      .count_i(count_q),
      .value_i(value_w),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[g]),
      .hit_o  (hits[g])
    );
  end

  assign found_d = res.found ? ValueWidth'(value_w) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= res.status;
      found_q  <= found_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;
  assign count_o       = count_q;

  `SLE_NEVER(a_count_range, clk_i, rst_ni, count_q > CW'(DEPTH), "count above capacity")
  `SLE_ASSERT(a_done_follows_start, clk_i, rst_ni, done_o |-> $past(start_i),
              "result without a request")
  `SLE_ASSERT(a_full_count, clk_i, rst_ni,
              (done_o && status_o == ST_FULL) |-> count_o == CW'(DEPTH),
              "full reported below capacity")
  `SLE_ASSERT(a_found_only_find, clk_i, rst_ni,
              (done_o && found_value_o != '0) |-> $past(mode_i) == MODE_FIND,
              "found value from a request that is not a find")
  `SLE_ASSERT(a_fail_keeps_count, clk_i, rst_ni,
              (done_o && status_o != ST_OK) |-> count_o == $past(count_o),
              "failed request changed the count")

endmodule
